### src/sfd_pkg.sv
package sfd_pkg;

    // parse phase codes
    localparam logic [2:0] PH_SOF0    = 3'd0;
    localparam logic [2:0] PH_SOF1    = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_TYPE    = 3'd3;
    localparam logic [2:0] PH_SEQ     = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CRC_HI  = 3'd6;
    localparam logic [2:0] PH_CRC_LO  = 3'd7;

    // frame status codes
    localparam logic [1:0] ST_INCOMPLETE = 2'd0;
    localparam logic [1:0] ST_OK         = 2'd1;
    localparam logic [1:0] ST_BAD_CRC    = 2'd2;

    // crc-16/ccitt-false constants
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // sync byte reset values
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;

    // configuration register indexes
    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    // one result beat
    typedef struct packed {
        logic [1:0] status;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_len;
        logic [7:0] frame_type;
        logic [7:0] frame_seq;
    } result_t;

    // one byte of the msb-first crc, unrolled over eight bit steps
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### src/sfd_parser.sv
module sfd_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           sync_first,
    input  logic [7:0]           sync_second,
    output sfd_pkg::result_t     result
);

    logic [2:0]  parse_phase_reg,   parse_phase_next;
    logic [7:0]  length_reg,        length_next;
    logic [7:0]  kind_reg,          kind_next;
    logic [7:0]  sequence_reg,      sequence_next;
    logic [7:0]  count_reg,         count_next;
    logic [7:0]  crc_high_reg,      crc_high_next;
    logic [15:0] crc_reg,           crc_next;
    logic [15:0] crc_upd;
    logic [8:0]  count_inc;

    // running crc seeded fresh on the length byte
    assign crc_upd   = sfd_pkg::crc_step((parse_phase_reg == sfd_pkg::PH_LEN) ?
                                         sfd_pkg::CRC_INIT : crc_reg, rx_byte);
    assign count_inc = {1'b0, count_reg} + 9'd1;

    // phase step for one byte
    always_comb
    begin
        parse_phase_next = parse_phase_reg;
        length_next      = length_reg;
        kind_next        = kind_reg;
        sequence_next    = sequence_reg;
        count_next       = count_reg;
        crc_high_next    = crc_high_reg;
        crc_next         = crc_reg;
        result.status        = sfd_pkg::ST_INCOMPLETE;
        result.payload_valid = 1'b0;
        result.payload_byte  = 8'h00;
        result.payload_index = 8'h00;
        unique case (parse_phase_reg)
            sfd_pkg::PH_SOF0:
            begin
                if (rx_byte == sync_first)
                begin
                    parse_phase_next = sfd_pkg::PH_SOF1;
                end
            end
            sfd_pkg::PH_SOF1:
            begin
                priority if (rx_byte == sync_second)
                begin
                    parse_phase_next = sfd_pkg::PH_LEN;
                end
                else if (rx_byte == sync_first)
                begin
                    parse_phase_next = sfd_pkg::PH_SOF1;
                end
                else
                begin
                    parse_phase_next = sfd_pkg::PH_SOF0;
                end
            end
            sfd_pkg::PH_LEN:
            begin
                length_next      = rx_byte;
                crc_next         = crc_upd;
                parse_phase_next = sfd_pkg::PH_TYPE;
            end
            sfd_pkg::PH_TYPE:
            begin
                kind_next        = rx_byte;
                crc_next         = crc_upd;
                parse_phase_next = sfd_pkg::PH_SEQ;
            end
            sfd_pkg::PH_SEQ:
            begin
                sequence_next    = rx_byte;
                crc_next         = crc_upd;
                count_next       = 8'h00;
                parse_phase_next = (length_reg == 8'h00) ? sfd_pkg::PH_CRC_HI
                                                         : sfd_pkg::PH_PAYLOAD;
            end
            sfd_pkg::PH_PAYLOAD:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = rx_byte;
                result.payload_index = count_reg;
                crc_next             = crc_upd;
                count_next           = count_inc[7:0];
                if (count_inc >= {1'b0, length_reg})
                begin
                    parse_phase_next = sfd_pkg::PH_CRC_HI;
                end
            end
            sfd_pkg::PH_CRC_HI:
            begin
                crc_high_next    = rx_byte;
                parse_phase_next = sfd_pkg::PH_CRC_LO;
            end
            sfd_pkg::PH_CRC_LO:
            begin
                result.status    = ({crc_high_reg, rx_byte} == crc_reg) ? sfd_pkg::ST_OK
                                                                        : sfd_pkg::ST_BAD_CRC;
                parse_phase_next = sfd_pkg::PH_SOF0;
            end
            default:
            begin
                parse_phase_next = sfd_pkg::PH_SOF0;
            end
        endcase
        result.frame_len  = length_next;
        result.frame_type = kind_next;
        result.frame_seq  = sequence_next;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase_reg <= sfd_pkg::PH_SOF0;
            length_reg      <= 8'h00;
            kind_reg        <= 8'h00;
            sequence_reg    <= 8'h00;
            count_reg       <= 8'h00;
            crc_high_reg    <= 8'h00;
            crc_reg         <= sfd_pkg::CRC_INIT;
        end
        else if (step)
        begin
            parse_phase_reg <= parse_phase_next;
            length_reg      <= length_next;
            kind_reg        <= kind_next;
            sequence_reg    <= sequence_next;
            count_reg       <= count_next;
            crc_high_reg    <= crc_high_next;
            crc_reg         <= crc_next;
        end
    end

endmodule

### src/sync_frame_deframer_crc16.sv
// Sync-framed packet deframer with a CRC-16/CCITT-FALSE check. One received byte
// is taken per beat and every byte gives exactly one result beat: payload bytes
// are forwarded with their index, and the beat of the low CRC byte carries the
// frame status (ok or bad CRC). A byte passes an input register, then the phase
// logic and the byte-wide unrolled CRC update into the result register; a new
// byte can be taken every cycle while the result is not stalled, as the CRC
// update of one byte per clock allows. The user writes the sync bytes
// over the configuration port only while idle; the block does not enforce it.
module sync_frame_deframer_crc16 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_index,
    output logic [7:0] frame_len,
    output logic [7:0] frame_type,
    output logic [7:0] frame_seq,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    sfd_pkg::result_t  result_reg;
    sfd_pkg::result_t  result_comb;
    logic [7:0]        sync_first_reg;
    logic [7:0]        sync_second_reg;
    logic              out_free;
    logic              step;

    // handshake chain through the two stages
    assign out_free = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= sfd_pkg::SYNC_FIRST_RST;
            sync_second_reg <= sfd_pkg::SYNC_SECOND_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                sfd_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                sfd_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                default:                  sync_first_reg  <= sync_first_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // phase logic and running crc
    sfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .result      (result_comb)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_comb;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = result_reg.status;
    assign payload_valid = result_reg.payload_valid;
    assign payload_byte  = result_reg.payload_byte;
    assign payload_index = result_reg.payload_index;
    assign frame_len     = result_reg.frame_len;
    assign frame_type    = result_reg.frame_type;
    assign frame_seq     = result_reg.frame_seq;

    // a frame status never comes on a payload beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> status == sfd_pkg::ST_INCOMPLETE)
        else $error("status reported on a payload beat");

    // payload index stays inside the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> payload_index < frame_len)
        else $error("payload index beyond frame length");

    // input is only held off by a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // a stalled stage with a free output moves on in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_free |=> out_valid)
        else $error("accepted beat lost between stages");

endmodule

### sim/sync_frame_deframer_crc16_tb.sv
module sync_frame_deframer_crc16_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // how a stimulus row turns into a byte
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_CRC_HI,
        ROW_CRC_LO
    } row_kind_t;

    // one stimulus row: for crc rows the value is an xor mask on the good crc byte
    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] value;
        logic       pin;
        logic [1:0] status;
    } stim_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_len;
    logic [7:0] frame_type;
    logic [7:0] frame_seq;
    logic       cfg_write = 1'b0;
    logic       cfg_index = sfd_pkg::CFG_SYNC_FIRST;
    logic [7:0] cfg_data  = 8'h00;

    // shadow of the deframer: sync setting and parse state
    logic [7:0]  sync_a   = sfd_pkg::SYNC_FIRST_RST;
    logic [7:0]  sync_b   = sfd_pkg::SYNC_SECOND_RST;
    logic [2:0]  phase    = sfd_pkg::PH_SOF0;
    logic [7:0]  hold_len = 8'h00;
    logic [7:0]  hold_kind = 8'h00;
    logic [7:0]  hold_seq = 8'h00;
    logic [7:0]  pay_cnt  = 8'h00;
    logic [7:0]  crc_hi   = 8'h00;
    logic [15:0] crc_acc  = sfd_pkg::CRC_INIT;

    sfd_pkg::result_t predicted_beats [$];
    stim_row_t        frame_rows [$];
    int               mismatches = 0;
    int               sent = 0;
    int               seen = 0;

    // directed rows: reset state, repeated first sync, empty frame,
    // extreme bytes, bad crc and a broken sync pair
    stim_row_t directed_rows [0:20] = '{
        '{ROW_BYTE,   8'h00,                    1'b1, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   sfd_pkg::SYNC_FIRST_RST,  1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   sfd_pkg::SYNC_FIRST_RST,  1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   sfd_pkg::SYNC_SECOND_RST, 1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'h00,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'hFF,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'h00,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_CRC_HI, 8'h00,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_CRC_LO, 8'h00,                    1'b1, sfd_pkg::ST_OK},
        '{ROW_BYTE,   sfd_pkg::SYNC_FIRST_RST,  1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   sfd_pkg::SYNC_SECOND_RST, 1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'h02,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'h00,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'hFF,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'hFF,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'h00,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_CRC_HI, 8'h00,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_CRC_LO, 8'h01,                    1'b1, sfd_pkg::ST_BAD_CRC},
        '{ROW_BYTE,   sfd_pkg::SYNC_FIRST_RST,  1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   8'h13,                    1'b0, sfd_pkg::ST_INCOMPLETE},
        '{ROW_BYTE,   sfd_pkg::SYNC_SECOND_RST, 1'b1, sfd_pkg::ST_INCOMPLETE}
    };

    sync_frame_deframer_crc16 dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .frame_len     (frame_len),
        .frame_type    (frame_type),
        .frame_seq     (frame_seq),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // crc-16/ccitt-false, one data bit at a time, msb first
    function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0} ^ (fb ? sfd_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    // advance the shadow parser by one byte and give the beat it should produce
    function automatic sfd_pkg::result_t deframe_byte(input logic [7:0] b);
        sfd_pkg::result_t r;
        r = '0;
        case (phase)
            sfd_pkg::PH_SOF0:
            begin
                if (b == sync_a)
                begin
                    phase = sfd_pkg::PH_SOF1;
                end
            end
            sfd_pkg::PH_SOF1:
            begin
                // second sync wins when both registers match
                if (b == sync_b)
                begin
                    phase = sfd_pkg::PH_LEN;
                end
                else if (b != sync_a)
                begin
                    phase = sfd_pkg::PH_SOF0;
                end
            end
            sfd_pkg::PH_LEN:
            begin
                hold_len = b;
                crc_acc  = ccitt_next(sfd_pkg::CRC_INIT, b);
                phase    = sfd_pkg::PH_TYPE;
            end
            sfd_pkg::PH_TYPE:
            begin
                hold_kind = b;
                crc_acc   = ccitt_next(crc_acc, b);
                phase     = sfd_pkg::PH_SEQ;
            end
            sfd_pkg::PH_SEQ:
            begin
                hold_seq = b;
                crc_acc  = ccitt_next(crc_acc, b);
                pay_cnt  = 8'h00;
                phase    = (hold_len == 8'h00) ? sfd_pkg::PH_CRC_HI : sfd_pkg::PH_PAYLOAD;
            end
            sfd_pkg::PH_PAYLOAD:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                r.payload_index = pay_cnt;
                crc_acc = ccitt_next(crc_acc, b);
                if ({1'b0, pay_cnt} + 9'd1 >= {1'b0, hold_len})
                begin
                    phase = sfd_pkg::PH_CRC_HI;
                end
                pay_cnt = pay_cnt + 8'd1;
            end
            sfd_pkg::PH_CRC_HI:
            begin
                crc_hi = b;
                phase  = sfd_pkg::PH_CRC_LO;
            end
            default:
            begin
                r.status = ({crc_hi, b} == crc_acc) ? sfd_pkg::ST_OK : sfd_pkg::ST_BAD_CRC;
                phase    = sfd_pkg::PH_SOF0;
            end
        endcase
        r.frame_len  = hold_len;
        r.frame_type = hold_kind;
        r.frame_seq  = hold_seq;
        return r;
    endfunction

    function automatic stim_row_t mk_row(input row_kind_t k, input logic [7:0] v);
        stim_row_t r;
        r.kind   = k;
        r.value  = v;
        r.pin    = 1'b0;
        r.status = sfd_pkg::ST_INCOMPLETE;
        return r;
    endfunction

    // payload length: mostly short, some medium, a few near the top
    function automatic logic [7:0] pick_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return 8'($urandom_range(0, 8));
        end
        if (roll < 96)
        begin
            return 8'($urandom_range(9, 40));
        end
        return 8'($urandom_range(250, 255));
    endfunction

    // one random frame: line noise, a truncated frame or a full frame
    task automatic build_frame();
        int         shape;
        int         n;
        logic [7:0] len;
        logic [7:0] mask_hi;
        logic [7:0] mask_lo;
        shape = $urandom_range(0, 99);
        if (shape < 12)
        begin
            n = $urandom_range(1, 8);
            repeat (n) frame_rows.push_back(mk_row(ROW_BYTE, 8'($urandom_range(0, 255))));
            return;
        end
        repeat ($urandom_range(0, 2))
            frame_rows.push_back(mk_row(ROW_BYTE, 8'($urandom_range(0, 255))));
        frame_rows.push_back(mk_row(ROW_BYTE, sync_a));
        if ($urandom_range(0, 5) == 0)
        begin
            frame_rows.push_back(mk_row(ROW_BYTE, sync_a));
        end
        frame_rows.push_back(mk_row(ROW_BYTE, sync_b));
        len = pick_len();
        frame_rows.push_back(mk_row(ROW_BYTE, len));
        frame_rows.push_back(mk_row(ROW_BYTE, 8'($urandom_range(0, 255))));
        frame_rows.push_back(mk_row(ROW_BYTE, 8'($urandom_range(0, 255))));
        // truncated frames stop part way through the payload or before the crc
        n = (shape < 22) ? int'($urandom_range(0, len)) : int'(len);
        repeat (n) frame_rows.push_back(mk_row(ROW_BYTE, 8'($urandom_range(0, 255))));
        if (shape < 22)
        begin
            return;
        end
        mask_hi = 8'h00;
        mask_lo = 8'h00;
        if ($urandom_range(0, 9) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                mask_hi = 8'($urandom_range(1, 255));
            end
            else
            begin
                mask_lo = 8'($urandom_range(1, 255));
            end
        end
        frame_rows.push_back(mk_row(ROW_CRC_HI, mask_hi));
        frame_rows.push_back(mk_row(ROW_CRC_LO, mask_lo));
    endtask

    // drive one row as an input beat; entered and left at a falling edge
    task automatic offer_row(input stim_row_t row);
        logic [7:0]       b;
        sfd_pkg::result_t r;
        case (row.kind)
            ROW_CRC_HI: b = crc_acc[15:8] ^ row.value;
            ROW_CRC_LO: b = crc_acc[7:0] ^ row.value;
            default:    b = row.value;
        endcase
        // random gaps, none in the calm stretch
        while (!(sent >= 900 && sent < 1300) && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        r = deframe_byte(b);
        if (row.pin)
        begin
            r.status = row.status;
        end
        predicted_beats.push_back(r);
        sent++;
        @(negedge clk);
    endtask

    // drain the block, then load both sync registers
    task automatic write_sync(input logic [7:0] first_sync, input logic [7:0] second_sync);
        in_valid <= 1'b0;
        while (predicted_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= sfd_pkg::CFG_SYNC_FIRST;
        cfg_data  <= first_sync;
        @(negedge clk);
        cfg_index <= sfd_pkg::CFG_SYNC_SECOND;
        cfg_data  <= second_sync;
        @(negedge clk);
        cfg_write <= 1'b0;
        sync_a = first_sync;
        sync_b = second_sync;
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // compare one result beat with the oldest prediction
    task automatic check_beat();
        sfd_pkg::result_t want;
        if (predicted_beats.size() == 0)
        begin
            $error("result beat with nothing predicted");
            mismatches++;
            return;
        end
        want = predicted_beats.pop_front();
        check_field("status", 8'(want.status), 8'(status));
        check_field("payload_valid", 8'(want.payload_valid), 8'(payload_valid));
        check_field("payload_byte", want.payload_byte, payload_byte);
        check_field("payload_index", want.payload_index, payload_index);
        check_field("frame_len", want.frame_len, frame_len);
        check_field("frame_type", want.frame_type, frame_type);
        check_field("frame_seq", want.frame_seq, frame_seq);
    endtask

    // result side: random stalls, one long hold-off, a calm stretch
    initial
    begin : result_sink
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && seen >= 300)
            begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= (seen >= 900 && seen < 1300) || $urandom_range(0, 99) >= 21;
            end
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_beat();
                seen++;
            end
        end
    end

    // reset, directed table, then random frames under several sync settings
    initial
    begin : byte_source
        logic [7:0] first_set [0:4];
        logic [7:0] second_set [0:4];
        int         quota;
        first_set  = '{sfd_pkg::SYNC_FIRST_RST, 8'h00, 8'hFF, 8'h3C, 8'h00};
        second_set = '{sfd_pkg::SYNC_SECOND_RST, 8'hFF, 8'h00, 8'h3C, 8'h00};
        first_set[4]  = 8'($urandom_range(0, 255));
        second_set[4] = 8'($urandom_range(0, 255));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_rows[i])
        begin
            offer_row(directed_rows[i]);
        end
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
            begin
                write_sync(first_set[p], second_set[p]);
            end
            quota = sent + 400;
            while (sent < quota)
            begin
                build_frame();
                while (frame_rows.size() != 0)
                begin
                    offer_row(frame_rows.pop_front());
                end
            end
        end
        in_valid <= 1'b0;
        while (predicted_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sync_frame_deframer_crc16.f
src/sfd_pkg.sv
src/sfd_parser.sv
src/sync_frame_deframer_crc16.sv
sim/sync_frame_deframer_crc16_tb.sv
